[design/bpu_pkg.sv]
// bpu_pkg: shared types and constants of the bitmap palette pixel unpacker
// holds the word layouts of both channels, command and register codes
// no dependencies
package bpu_pkg;

    // widths fixed by the word layouts
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int INDEX_W    = 24;
    localparam int COLOR_W    = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // command codes of an input word
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        DEPTH_1BPP  = 2'd0,
        DEPTH_4BPP  = 2'd1,
        DEPTH_8BPP  = 2'd2,
        DEPTH_24BPP = 2'd3
    } t_depth;

    // which byte of a 24-bit pixel comes next
    typedef enum logic [1:0] {
        TRIP_BLUE  = 2'd0,
        TRIP_GREEN = 2'd1,
        TRIP_RED   = 2'd2
    } t_trip;

    typedef struct packed {
        logic       command;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [INDEX_W-1:0] pixel_index;
        logic               last_of_run;
        logic               image_done;
    } t_out_word;

endpackage

[design/bpu_stream_if.sv]
// bpu_stream_if: valid/ready channel carrying one word of type T
// used with bpu_pkg word types
interface bpu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/bpu_ram.sv]
// bpu_ram: generic single write port, single read port ram with registered read
// no dependencies
module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/bmp_palette_pixel_unpacker.sv]
// bmp_palette_pixel_unpacker: top level, bitmap pixel bytes to 24-bit rgb pixels
// depends on bpu_pkg, bpu_stream_if and bpu_ram
// a word waits in the holding register; its pixels leave through the output register
// one pixel per cycle while o_pix is not stalled, set by the single table read port;
//   1 bpp gives up to 8 pixels a byte, 4 bpp up to 2, 8 bpp one, 24 bpp one per 3 bytes
// reset (synchronous, active low): depth 8 bpp, width and height 1, row 0 column 0,
//   all phases cleared; color table contents stay undefined until written
module bmp_palette_pixel_unpacker #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bpu_stream_if.sink                      i_pix,
    bpu_stream_if.source                    o_pix
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = RW + CW;
    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int IW = bpu_pkg::INDEX_W;

    // what travels with a table read to the output register
    typedef struct packed {
        logic                             direct;
        logic [bpu_pkg::COLOR_W-1:0]      rgb;
        logic [IW-1:0]                    pixel_index;
        logic                             last_of_run;
        logic                             image_done;
    } t_pix_meta;

    // configuration registers
    bpu_pkg::t_depth               r_depth;
    logic [bpu_pkg::CFG_DATA_W-1:0] r_width;
    logic [bpu_pkg::CFG_DATA_W-1:0] r_height;

    // effective dimensions: zero reads as one, large values saturate
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [RW-1:0] h_m1;
    logic [PW-1:0] base_prod;
    logic [IW-1:0] r_base_top;     // (height-1)*width, refreshed every cycle

    // unpacking position
    logic [CW-1:0]         r_col, n_col;
    logic [RW-1:0]         r_row, n_row;
    logic [1:0]            r_phase, n_phase;
    logic                  r_skip, n_skip;
    bpu_pkg::t_trip        r_trip, n_trip;
    logic [15:0]           r_held, n_held;
    logic [IW-1:0]         r_row_off, n_row_off;   // row*width

    // word holding register
    logic                  r_busy;
    bpu_pkg::t_in_word     r_item;
    logic [2:0]            r_bit;
    logic [2:0]            start_bit;

    // output stage
    logic                  r_s2_valid;
    t_pix_meta             r_s2, n_s2;
    logic [bpu_pkg::COLOR_W-1:0] ram_q;

    logic          s2_free, is_data, in_image, wants_pix, emit, pix_last, done, accept;
    logic          byte_end, row_step, restart;
    logic [CW-1:0] col_p1;
    logic [1:0]    phase_n;
    logic [AW-1:0] raddr;

    always_comb begin
        if (r_width == '0) begin
            eff_w = CW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = RW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(r_height);
        end
    end

    assign h_m1      = eff_h - RW'(1);
    assign base_prod = PW'(h_m1) * PW'(eff_w);

    // control of the holding register
    assign s2_free  = !r_s2_valid || o_pix.ready;
    assign is_data  = (r_item.command == bpu_pkg::CMD_PIXEL);
    assign in_image = (r_row < eff_h);
    assign col_p1   = r_col + CW'(1);

    // 24 bpp yields a pixel only on the red byte; padding and bytes past the image none
    assign wants_pix = r_busy && is_data && in_image && !r_skip &&
                       (r_depth != bpu_pkg::DEPTH_24BPP || r_trip == bpu_pkg::TRIP_RED);
    assign emit      = wants_pix && s2_free;

    always_comb begin
        unique case (r_depth)
            bpu_pkg::DEPTH_1BPP, bpu_pkg::DEPTH_4BPP: begin
                pix_last = (r_bit == 3'd0) || (col_p1 >= eff_w);
            end
            default: begin
                pix_last = 1'b1;
            end
        endcase
    end

    assign done     = r_busy && (!wants_pix || (emit && pix_last));
    assign byte_end = done && is_data && in_image;
    assign accept   = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_busy || done;

    assign restart = i_cfg_we && (i_cfg_idx == bpu_pkg::REG_DEPTH_MODE ||
                                  i_cfg_idx == bpu_pkg::REG_IMAGE_WIDTH ||
                                  i_cfg_idx == bpu_pkg::REG_IMAGE_HEIGHT);

    // first pixel position in a byte, counted down toward bit 0
    always_comb begin
        unique case (r_depth)
            bpu_pkg::DEPTH_1BPP: start_bit = 3'd7;
            bpu_pkg::DEPTH_4BPP: start_bit = 3'd1;
            default:             start_bit = 3'd0;
        endcase
    end

    // color table address: msb first at 1 bpp, high nibble first at 4 bpp
    always_comb begin
        unique case (r_depth)
            bpu_pkg::DEPTH_1BPP: raddr = AW'(r_item.data_byte[r_bit]);
            bpu_pkg::DEPTH_4BPP: raddr = r_bit[0] ? AW'(r_item.data_byte[7:4])
                                                  : AW'(r_item.data_byte[3:0]);
            default:             raddr = AW'(r_item.data_byte);
        endcase
    end

    bpu_ram #(
        .WIDTH (bpu_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_color_table (
        .i_clk   (i_clk),
        .i_we    (r_busy && r_item.command == bpu_pkg::CMD_PALETTE),
        .i_waddr (AW'(r_item.palette_index)),
        .i_wdata ({r_item.palette_red, r_item.palette_green, r_item.palette_blue}),
        .i_re    (emit),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // pixel metadata; buffer index is (height-1-row)*width + col modulo 2^24
    always_comb begin
        n_s2.direct      = (r_depth == bpu_pkg::DEPTH_24BPP);
        n_s2.rgb         = {r_item.data_byte, r_held};
        n_s2.pixel_index = r_base_top - r_row_off + IW'(r_col);
        n_s2.last_of_run = pix_last;
        n_s2.image_done  = (r_row == h_m1) && (r_col == eff_w - CW'(1));
    end

    // position bookkeeping: column per pixel, the rest at the end of each data byte
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_phase   = r_phase;
        n_skip    = r_skip;
        n_trip    = r_trip;
        n_held    = r_held;
        n_row_off = r_row_off;
        row_step  = 1'b0;
        phase_n   = r_phase + 2'd1;
        if (emit) begin
            n_col = col_p1;
        end
        if (byte_end) begin
            n_phase = phase_n;
            if (r_skip) begin
                // padding byte, row ends on the 4-byte boundary
                if (phase_n == 2'd0) begin
                    row_step = 1'b1;
                end
            end else begin
                if (r_depth == bpu_pkg::DEPTH_24BPP) begin
                    unique case (r_trip)
                        bpu_pkg::TRIP_BLUE: begin
                            n_held = {8'h00, r_item.data_byte};
                            n_trip = bpu_pkg::TRIP_GREEN;
                        end
                        bpu_pkg::TRIP_GREEN: begin
                            n_held = {r_item.data_byte, r_held[7:0]};
                            n_trip = bpu_pkg::TRIP_RED;
                        end
                        default: begin
                            n_trip = bpu_pkg::TRIP_BLUE;
                        end
                    endcase
                end
                if (n_col >= eff_w) begin
                    if (phase_n == 2'd0) begin
                        row_step = 1'b1;
                    end else begin
                        n_skip = 1'b1;
                    end
                end
            end
        end
        if (row_step) begin
            n_col     = '0;
            n_skip    = 1'b0;
            n_row     = r_row + RW'(1);
            n_row_off = r_row_off + IW'(eff_w);
        end
        if (restart) begin
            n_col     = '0;
            n_row     = '0;
            n_phase   = '0;
            n_skip    = 1'b0;
            n_trip    = bpu_pkg::TRIP_BLUE;
            n_held    = '0;
            n_row_off = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= bpu_pkg::DEPTH_8BPP;
            r_width    <= bpu_pkg::CFG_DATA_W'(1);
            r_height   <= bpu_pkg::CFG_DATA_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_phase    <= '0;
            r_skip     <= 1'b0;
            r_trip     <= bpu_pkg::TRIP_BLUE;
            r_held     <= '0;
            r_row_off  <= '0;
            r_busy     <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bpu_pkg::REG_DEPTH_MODE:   r_depth  <= bpu_pkg::t_depth'(i_cfg_data[1:0]);
                    bpu_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    bpu_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col     <= n_col;
            r_row     <= n_row;
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_trip    <= n_trip;
            r_held    <= n_held;
            r_row_off <= n_row_off;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_s2_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base_top <= IW'(base_prod);
        if (accept) begin
            r_item <= i_pix.data;
            r_bit  <= start_bit;
        end else if (emit && !pix_last) begin
            r_bit <= r_bit - 3'd1;
        end
        if (emit) begin
            r_s2 <= n_s2;
        end
    end

    // table data arrives with the metadata; 24 bpp pixels bypass the table
    assign o_pix.valid            = r_s2_valid;
    assign o_pix.data.red         = r_s2.direct ? r_s2.rgb[23:16] : ram_q[23:16];
    assign o_pix.data.green       = r_s2.direct ? r_s2.rgb[15:8]  : ram_q[15:8];
    assign o_pix.data.blue        = r_s2.direct ? r_s2.rgb[7:0]   : ram_q[7:0];
    assign o_pix.data.pixel_index = r_s2.pixel_index;
    assign o_pix.data.last_of_run = r_s2.last_of_run;
    assign o_pix.data.image_done  = r_s2.image_done;

endmodule

[tb/bmp_palette_pixel_unpacker_tb.sv]
// testbench for bmp_palette_pixel_unpacker: palette loads, bitmap byte streams at all
// four depths, checked pixel by pixel against an in-bench unpacking model
// depends on bpu_pkg, bpu_stream_if and the block itself
`timescale 1ns / 100ps

module bmp_palette_pixel_unpacker_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    // slack for the block to finish a byte: up to eight pixels per byte, plus margin
    localparam int DRAIN_SLACK    = 24;
    // longest receiver hold-off is HOLD_CYCLES, far under this, so this only trips on a real hang
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_WORDS   = 50;
    localparam int MAX_PRINTED    = 40;
    localparam int DIM_LIMIT      = 4096;
    localparam int PALETTE_SIZE   = 256;

    // index past the register list, must be a no-op
    localparam logic [bpu_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bpu_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bpu_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bpu_stream_if #(.T(bpu_pkg::t_in_word))  pix_in ();
    bpu_stream_if #(.T(bpu_pkg::t_out_word)) pix_out ();

    bmp_palette_pixel_unpacker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // unpacking model: configuration, color table and row walk state
    // ------------------------------------------------------------------
    bpu_pkg::t_depth cur_depth;
    logic [12:0]     cur_width;
    logic [12:0]     cur_height;
    logic [23:0]     color_tbl [PALETTE_SIZE];
    int              col_cnt;
    int              row_cnt;
    logic [1:0]      row_phase;
    logic            pad_skip;
    bpu_pkg::t_trip  trip;
    logic [15:0]     held_bg;
    logic [23:0]     row_base;

    // pixels predicted but not yet seen on the output, oldest first
    bpu_pkg::t_out_word pending_pixels [$];

    int err_count      = 0;
    int pixels_checked = 0;
    int words_accepted = 0;
    int words_sent     = 0;
    int frames_run     = 0;
    int stall_cycles   = 0;
    int tx_burst_left  = 0;
    int rx_hold_req    = 0;
    int rx_hold_left   = 0;
    int rx_seg_left    = 0;
    t_rx_mode rx_mode  = RX_OPEN;

    // zero reads as one, anything past the limit saturates
    function automatic int eff_dim(logic [12:0] v);
        if (v == '0) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return int'(v);
    endfunction

    // rows arrive bottom first, so row r lands at (height-1-r)*width
    function automatic void set_row_base();
        int h;
        h = eff_dim(cur_height);
        if (row_cnt < h) row_base = 24'((h - 1 - row_cnt) * eff_dim(cur_width));
        else row_base = '0;
    endfunction

    function automatic void restart_unpack();
        col_cnt   = 0;
        row_cnt   = 0;
        row_phase = '0;
        pad_skip  = 1'b0;
        trip      = bpu_pkg::TRIP_BLUE;
        held_bg   = '0;
        set_row_base();
    endfunction

    function automatic void next_row();
        col_cnt  = 0;
        pad_skip = 1'b0;
        row_cnt++;
        set_row_base();
    endfunction

    function automatic void reset_model();
        cur_depth  = bpu_pkg::DEPTH_8BPP;
        cur_width  = 13'd1;
        cur_height = 13'd1;
        restart_unpack();
    endfunction

    // any listed register restarts the walk; the color table survives
    function automatic void apply_reg(logic [bpu_pkg::CFG_IDX_W-1:0] idx,
                                      logic [bpu_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            bpu_pkg::REG_DEPTH_MODE: begin
                cur_depth = bpu_pkg::t_depth'(val[1:0]);
                restart_unpack();
            end
            bpu_pkg::REG_IMAGE_WIDTH: begin
                cur_width = val;
                restart_unpack();
            end
            bpu_pkg::REG_IMAGE_HEIGHT: begin
                cur_height = val;
                restart_unpack();
            end
            default: ;
        endcase
    endfunction

    function automatic bpu_pkg::t_out_word make_pixel(logic [23:0] rgb);
        bpu_pkg::t_out_word p;
        p.red         = rgb[23:16];
        p.green       = rgb[15:8];
        p.blue        = rgb[7:0];
        p.pixel_index = row_base + 24'(col_cnt);
        p.last_of_run = 1'b0;
        p.image_done  = (row_cnt == eff_dim(cur_height) - 1) &&
                        (col_cnt == eff_dim(cur_width) - 1);
        col_cnt++;
        return p;
    endfunction

    // one accepted word in, zero to eight predicted pixels queued
    function automatic void unpack_word(bpu_pkg::t_in_word wd);
        bpu_pkg::t_out_word run [8];
        int                 n;
        int                 w;
        logic [7:0]         b;
        n = 0;
        w = eff_dim(cur_width);
        b = wd.data_byte;
        if (wd.command == bpu_pkg::CMD_PALETTE) begin
            color_tbl[wd.palette_index] = {wd.palette_red, wd.palette_green, wd.palette_blue};
            return;
        end
        // past the last row everything is dropped
        if (row_cnt >= eff_dim(cur_height)) return;
        // row padding up to the 4-byte boundary
        if (pad_skip) begin
            row_phase++;
            if (row_phase == 2'd0) next_row();
            return;
        end
        case (cur_depth)
            bpu_pkg::DEPTH_1BPP: begin
                // msb first, spare low bits of a row's last byte fall away
                for (int i = 7; i >= 0 && col_cnt < w; i--) begin
                    run[n] = make_pixel(color_tbl[b[i]]);
                    n++;
                end
            end
            bpu_pkg::DEPTH_4BPP: begin
                run[n] = make_pixel(color_tbl[b[7:4]]);
                n++;
                if (col_cnt < w) begin
                    run[n] = make_pixel(color_tbl[b[3:0]]);
                    n++;
                end
            end
            bpu_pkg::DEPTH_8BPP: begin
                run[n] = make_pixel(color_tbl[b]);
                n++;
            end
            default: begin
                // blue, green, red on the wire; pixel goes out on red
                case (trip)
                    bpu_pkg::TRIP_BLUE: begin
                        held_bg = {8'h00, b};
                        trip    = bpu_pkg::TRIP_GREEN;
                    end
                    bpu_pkg::TRIP_GREEN: begin
                        held_bg[15:8] = b;
                        trip          = bpu_pkg::TRIP_RED;
                    end
                    default: begin
                        run[n] = make_pixel({b, held_bg});
                        n++;
                        trip = bpu_pkg::TRIP_BLUE;
                    end
                endcase
            end
        endcase
        if (n > 0) run[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++) pending_pixels.push_back(run[k]);
        row_phase++;
        if (col_cnt >= w) begin
            if (row_phase == 2'd0) next_row();
            else pad_skip = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // everything is sampled at the rising edge: register writes, input words into
    // the model, output words against the oldest prediction
    always @(posedge i_clk) begin : monitor
        bpu_pkg::t_out_word want;
        logic               moved;
        if (!i_rst_n) begin
            reset_model();
            stall_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) apply_reg(i_cfg_idx, i_cfg_data);
            if (pix_in.valid && pix_in.ready) begin
                unpack_word(pix_in.data);
                words_accepted++;
                moved = 1'b1;
            end
            if (pix_out.valid && pix_out.ready) begin
                moved = 1'b1;
                if (pending_pixels.size() == 0) begin
                    report_mismatch("pixel with nothing pending", 64'(pix_out.data), '0);
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (pix_out.data.red !== want.red)
                        report_mismatch("red", pix_out.data.red, want.red);
                    if (pix_out.data.green !== want.green)
                        report_mismatch("green", pix_out.data.green, want.green);
                    if (pix_out.data.blue !== want.blue)
                        report_mismatch("blue", pix_out.data.blue, want.blue);
                    if (pix_out.data.pixel_index !== want.pixel_index)
                        report_mismatch("pixel_index", pix_out.data.pixel_index,
                                        want.pixel_index);
                    if (pix_out.data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", pix_out.data.last_of_run,
                                        want.last_of_run);
                    if (pix_out.data.image_done !== want.image_done)
                        report_mismatch("image_done", pix_out.data.image_done,
                                        want.image_done);
                end
            end
            if (moved) stall_cycles = 0;
            else stall_cycles++;
        end
    end

    // hang detection: nothing moved on either channel for too long
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no word moved for %0d cycles, %0d pixels still pending",
                 WATCHDOG_LIMIT, pending_pixels.size());
        $display("** bmp_palette_pixel_unpacker: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: segments of open, coin-flip, sparse and toggling ready,
    // plus a long hold-off on request, counted here
    // ------------------------------------------------------------------
    initial begin
        pix_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pix_out.ready <= 1'b0;
            end else begin
                if (rx_seg_left == 0) begin
                    rx_mode     = t_rx_mode'($urandom_range(3));
                    rx_seg_left = $urandom_range(8, 64);
                end
                rx_seg_left--;
                case (rx_mode)
                    RX_OPEN:   pix_out.ready <= 1'b1;
                    RX_COIN:   pix_out.ready <= 1'($urandom_range(1));
                    RX_SPARSE: pix_out.ready <= ($urandom_range(3) == 0);
                    default:   pix_out.ready <= ~pix_out.ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    function automatic bpu_pkg::t_in_word random_word();
        bpu_pkg::t_in_word wd;
        wd.command       = 1'($urandom_range(1));
        wd.palette_index = 8'($urandom);
        wd.palette_red   = 8'($urandom);
        wd.palette_green = 8'($urandom);
        wd.palette_blue  = 8'($urandom);
        wd.data_byte     = 8'($urandom);
        return wd;
    endfunction

    // bursts of random length with random gaps between them; some bursts
    // follow the previous one with no gap at all
    task automatic send_word(bpu_pkg::t_in_word wd);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                pix_in.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        pix_in.valid <= 1'b1;
        pix_in.data  <= wd;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        tx_burst_left--;
        words_sent++;
    endtask

    // unused palette fields carry random bits so every input bit toggles
    task automatic send_pixel_byte(logic [7:0] b);
        bpu_pkg::t_in_word wd;
        wd           = random_word();
        wd.command   = bpu_pkg::CMD_PIXEL;
        wd.data_byte = b;
        send_word(wd);
    endtask

    task automatic send_palette(logic [7:0] idx, logic [23:0] rgb);
        bpu_pkg::t_in_word wd;
        wd               = random_word();
        wd.command       = bpu_pkg::CMD_PALETTE;
        wd.palette_index = idx;
        {wd.palette_red, wd.palette_green, wd.palette_blue} = rgb;
        send_word(wd);
    endtask

    task automatic send_image_bytes(int count, bit mix_palette);
        repeat (count) begin
            if (mix_palette && $urandom_range(11) == 0)
                send_palette(8'($urandom), 24'($urandom));
            send_pixel_byte(8'($urandom));
        end
    endtask

    // sender goes quiet until every predicted pixel has come out, then lets
    // the block finish any byte that produced nothing
    task automatic wait_drained();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        tx_burst_left = 0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bpu_pkg::CFG_IDX_W-1:0] idx,
                             logic [bpu_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic configure(bpu_pkg::t_depth d, int w, int h);
        wait_drained();
        write_reg(bpu_pkg::REG_DEPTH_MODE, bpu_pkg::CFG_DATA_W'(d));
        write_reg(bpu_pkg::REG_IMAGE_WIDTH, bpu_pkg::CFG_DATA_W'(w));
        write_reg(bpu_pkg::REG_IMAGE_HEIGHT, bpu_pkg::CFG_DATA_W'(h));
        frames_run++;
    endtask

    // bytes in a whole image, each row padded to a multiple of four
    function automatic int frame_bytes(bpu_pkg::t_depth d, int w, int h);
        int ew;
        int row;
        ew = eff_dim(bpu_pkg::CFG_DATA_W'(w));
        case (d)
            bpu_pkg::DEPTH_1BPP: row = (ew + 7) / 8;
            bpu_pkg::DEPTH_4BPP: row = (ew + 1) / 2;
            bpu_pkg::DEPTH_8BPP: row = ew;
            default:             row = 3 * ew;
        endcase
        return ((row + 3) & ~3) * eff_dim(bpu_pkg::CFG_DATA_W'(h));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // whole color table first so no lookup ever hits an unwritten entry;
    // entry 0 black and 255 white for the color extremes
    task automatic test_palette_load();
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (i == 0) send_palette(8'(i), 24'h000000);
            else if (i == PALETTE_SIZE - 1) send_palette(8'(i), 24'hFFFFFF);
            else send_palette(8'(i), 24'($urandom));
        end
    endtask

    // out of reset: 8 bpp, 1x1 image, one pixel, three padding bytes, then
    // a byte past the image that must be dropped
    task automatic test_reset_defaults();
        send_pixel_byte(8'hFF);
        send_image_bytes(3, 1'b0);
        send_pixel_byte(8'h00);
    endtask

    // sub-byte depths with spare bits in the last byte of the row
    task automatic test_each_depth();
        configure(bpu_pkg::DEPTH_1BPP, 10, 1);
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'h80);
        send_image_bytes(2, 1'b0);
        configure(bpu_pkg::DEPTH_4BPP, 3, 1);
        send_pixel_byte(8'h0F);
        send_pixel_byte(8'hF0);
        send_image_bytes(2, 1'b0);
    endtask

    // zero width and height read as one; 24 bpp triplet, one pad byte, one extra
    task automatic test_dimension_clamp();
        configure(bpu_pkg::DEPTH_24BPP, 0, 0);
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'h80);
        send_image_bytes(2, 1'b0);
    endtask

    // a write past the register list leaves the walk alone; a real one restarts it
    task automatic test_restart();
        configure(bpu_pkg::DEPTH_8BPP, 4, 2);
        send_image_bytes(2, 1'b0);
        wait_drained();
        write_reg(REG_SPARE, 13'h1FFF);
        send_image_bytes(3, 1'b0);
        wait_drained();
        write_reg(bpu_pkg::REG_IMAGE_WIDTH, 13'd4);
        send_image_bytes(9, 1'b1);
    endtask

    // saturated width and full height: the start of the bottom row lands
    // near the top of the buffer index range
    task automatic test_full_width_row();
        configure(bpu_pkg::DEPTH_1BPP, 8191, 4096);
        send_image_bytes(16, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_backpressure();
        configure(bpu_pkg::DEPTH_1BPP, 64, 3);
        rx_hold_req = HOLD_CYCLES;
        send_image_bytes(frame_bytes(bpu_pkg::DEPTH_1BPP, 64, 3), 1'b0);
        wait_drained();
    endtask

    // mostly complete small images with random content; some cut short, some
    // with trailing bytes, now and then a burst of random words between frames
    task automatic test_random_frames();
        int              start;
        int              total;
        int              w;
        int              h;
        bpu_pkg::t_depth d;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4)) send_word(random_word());
            end
            d = bpu_pkg::t_depth'($urandom_range(3));
            case ($urandom_range(19))
                0:       w = 0;
                1, 2:    w = $urandom_range(13, 32);
                default: w = $urandom_range(1, 12);
            endcase
            h = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
            // wide rows stay one row high
            if (w > 12) h = 1;
            configure(d, w, h);
            total = frame_bytes(d, w, h);
            if ($urandom_range(5) == 0) total = $urandom_range(total - 1);
            else if ($urandom_range(3) == 0) total += $urandom_range(1, 3);
            send_image_bytes(total, 1'b1);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        pix_in.valid = 1'b0;
        pix_in.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_palette_load();
        test_reset_defaults();
        test_each_depth();
        test_dimension_clamp();
        test_restart();
        test_full_width_row();
        test_backpressure();
        test_random_frames();

        wait_drained();
        $display("covered %0d frames over all four depths: %0d words in, %0d pixels checked",
                 frames_run, words_accepted, pixels_checked);
        $display("with clamped sizes, restarts, a saturated frame size and a long output stall");
        if (err_count == 0) begin
            $display("** bmp_palette_pixel_unpacker: PASSED **");
        end else begin
            $display("%0d mismatches", err_count);
            $display("** bmp_palette_pixel_unpacker: FAILED **");
        end
        $finish;
    end

endmodule
